### hw/rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Types, codes and helper functions shared by the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int STQ_DEPTH = 16;

    localparam int SEC_W  = 32;
    localparam int USEC_W = 20;
    localparam int ID_W   = 8;
    localparam int MODE_W = 2;

    localparam logic [USEC_W-1:0] USEC_MAX     = USEC_W'(999999);
    localparam logic [USEC_W:0]   USEC_PER_SEC = (USEC_W+1)'(1000000);

    // Operation codes; the unused code behaves as a check.
    localparam logic [1:0] OP_CHECK  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Timer modes.
    localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SELECT = 2'd2;

    // Insert outcome codes.
    localparam logic [1:0] INS_OK     = 2'd0;
    localparam logic [1:0] INS_PASSED = 2'd1;
    localparam logic [1:0] INS_FULL   = 2'd2;
    localparam logic [1:0] INS_NONE   = 2'd3;

    // Result kinds.
    localparam logic KIND_EXPIRED = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_INSERT,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
        logic [ID_W-1:0]   id;
        logic [MODE_W-1:0] mode;
    } t_entry;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic shift_left;
        logic insert;
    } t_cell_ctl;

    // Saturate a microsecond value to the top of its range.
    function automatic logic [USEC_W-1:0] clamp_usec(input logic [USEC_W-1:0] v);
        return (v > USEC_MAX) ? USEC_MAX : v;
    endfunction

    // True when time a is strictly earlier than time b.
    function automatic logic earlier(input logic [SEC_W-1:0] a_sec,
                                     input logic [USEC_W-1:0] a_usec,
                                     input logic [SEC_W-1:0] b_sec,
                                     input logic [USEC_W-1:0] b_usec);
        return (a_sec < b_sec) || ((a_sec == b_sec) && (a_usec < b_usec));
    endfunction

endpackage

### hw/rtl/stq_cell.sv
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain. It holds an entry, compares it with the key
// being inserted, and moves data to or from its neighbors.
// ----------------------------------------------------------------------------
module stq_cell (
    input  logic              i_clk,
    input  stq_pkg::t_cell_ctl i_ctl,
    input  logic              i_occupied,
    input  stq_pkg::t_entry   i_key,
    input  stq_pkg::t_entry   i_left_entry,
    input  logic              i_left_lt,
    input  stq_pkg::t_entry   i_right_entry,
    output stq_pkg::t_entry   o_entry,
    output logic              o_lt
);
    import stq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // An occupied entry earlier than the key stays where it is on insert.
    assign o_lt    = i_occupied && earlier(r_entry.sec, r_entry.usec, i_key.sec, i_key.usec);
    assign o_entry = r_entry;

    // Pop moves everything one slot toward the head; insert opens a gap at
    // the first entry that is not earlier than the key.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_left) begin
            n_entry = i_right_entry;
        end else if (i_ctl.insert && !o_lt) begin
            n_entry = i_left_lt ? i_key : i_left_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hw/rtl/sorted_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit
// Steps: a transaction is taken only while idle; a check or an insert then pops each
// expired entry from the head cell, an insert places its key unless it has passed or
// the queue is full, and a summary closes it (a clear goes straight to the summary).
// Pops and the summary wait on output stalls; the single head comparison and the sequencer set the pace.
// Reset (synchronous, active low) empties the queue and idles the sequencer.
// ----------------------------------------------------------------------------
module sorted_timer_queue_unit #(
    parameter int DEPTH = stq_pkg::STQ_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_op,
    input  logic [stq_pkg::ID_W-1:0]    i_waiter_id,
    input  logic [stq_pkg::MODE_W-1:0]  i_timer_mode,
    input  logic [stq_pkg::SEC_W-1:0]   i_wake_sec,
    input  logic [stq_pkg::USEC_W-1:0]  i_wake_usec,
    input  logic [stq_pkg::SEC_W-1:0]   i_now_sec,
    input  logic [stq_pkg::USEC_W-1:0]  i_now_usec,
    // Output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_kind,
    output logic [stq_pkg::ID_W-1:0]    o_expired_id,
    output logic [1:0]                  o_timeout_status,
    output logic [1:0]                  o_insert_status,
    output logic                        o_queue_was_nonempty,
    output logic [stq_pkg::SEC_W-1:0]   o_head_sec,
    output logic [stq_pkg::USEC_W-1:0]  o_head_usec,
    output logic [stq_pkg::SEC_W-1:0]   o_delay_sec,
    output logic [stq_pkg::USEC_W-1:0]  o_delay_usec,
    output logic                        o_last
);
    import stq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   expired_id;
        logic [1:0]        timeout_status;
        logic [1:0]        insert_status;
        logic              nonempty;
        logic [SEC_W-1:0]  head_sec;
        logic [USEC_W-1:0] head_usec;
        logic [SEC_W-1:0]  delay_sec;
        logic [USEC_W-1:0] delay_usec;
        logic              last;
    } t_result;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [1:0]         r_op;
    t_entry             r_key;
    logic [SEC_W-1:0]   r_now_sec;
    logic [USEC_W-1:0]  r_now_usec;
    logic               r_nonempty;
    logic               r_popped;
    logic [1:0]         r_ins_status;
    logic               r_out_valid;
    t_result            r_out;

    logic               accept;
    logic               out_free;
    logic               head_expired;
    logic               pop_fire;
    logic               ins_fire;
    logic               sum_fire;
    logic [1:0]         ins_status;
    t_cell_ctl          cell_ctl;
    t_result            pop_result;
    t_result            sum_result;
    t_entry             head;
    logic               head_valid;
    logic [USEC_W:0]    usec_diff;
    logic               usec_borrow;

    t_entry             cell_entry [DEPTH];
    logic               cell_lt    [DEPTH];

    // Chain of cells; slot 0 is the head of the queue.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry left_entry;
        logic   left_lt;
        t_entry right_entry;

        if (g == 0) begin : g_first
            assign left_entry = r_key;
            assign left_lt    = 1'b1;
        end else begin : g_inner
            assign left_entry = cell_entry[g-1];
            assign left_lt    = cell_lt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[g];
        end else begin : g_mid
            assign right_entry = cell_entry[g+1];
        end

        stq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_occupied    (CNT_W'(g) < r_count),
            .i_key         (r_key),
            .i_left_entry  (left_entry),
            .i_left_lt     (left_lt),
            .i_right_entry (right_entry),
            .o_entry       (cell_entry[g]),
            .o_lt          (cell_lt[g])
        );
    end

    assign head       = cell_entry[0];
    assign head_valid = (r_count != '0);

    // Handshake; nothing is taken while reset is held.
    assign o_stall  = (r_state != ST_IDLE) || !i_rst_n;
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign head_expired = head_valid && earlier(head.sec, head.usec, r_now_sec, r_now_usec);

    // Outcome of an insert once the expired entries are gone.
    always_comb begin
        if (earlier(r_key.sec, r_key.usec, r_now_sec, r_now_usec)) begin
            ins_status = INS_PASSED;
        end else if (r_count == CNT_W'(DEPTH)) begin
            ins_status = INS_FULL;
        end else begin
            ins_status = INS_OK;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_op == OP_CLEAR) ? ST_SUM : ST_POP;
                end
            end
            ST_POP: begin
                if (!head_expired) begin
                    n_state = (r_op == OP_INSERT) ? ST_INSERT : ST_SUM;
                end
            end
            ST_INSERT: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        pop_fire = 1'b0;
        ins_fire = 1'b0;
        sum_fire = 1'b0;
        unique case (r_state)
            ST_IDLE:   ;
            ST_POP:    pop_fire = head_expired && out_free;
            ST_INSERT: ins_fire = (ins_status == INS_OK);
            ST_SUM:    sum_fire = out_free;
            default:   ;
        endcase
        cell_ctl.shift_left = pop_fire;
        cell_ctl.insert     = ins_fire;
    end

    // Report for the entry leaving the head.
    always_comb begin
        pop_result                = '0;
        pop_result.kind           = KIND_EXPIRED;
        pop_result.expired_id     = head.id;
        pop_result.timeout_status = (head.mode == MODE_SEM || head.mode == MODE_SELECT) ?
                                    head.mode : MODE_PLAIN;
        pop_result.insert_status  = INS_NONE;
        pop_result.nonempty       = 1'b1;
    end

    // Delay from now to the head, borrowing a second when needed.
    assign usec_borrow = (head.usec < r_now_usec);
    assign usec_diff   = usec_borrow ?
                         ({1'b0, head.usec} + USEC_PER_SEC - {1'b0, r_now_usec}) :
                         ({1'b0, head.usec} - {1'b0, r_now_usec});

    // Closing summary.
    always_comb begin
        sum_result               = '0;
        sum_result.kind          = KIND_SUMMARY;
        sum_result.insert_status = r_ins_status;
        sum_result.nonempty      = r_nonempty;
        sum_result.last          = 1'b1;
        if (head_valid) begin
            sum_result.head_sec  = head.sec;
            sum_result.head_usec = head.usec;
            if (!r_popped) begin
                sum_result.delay_sec  = head.sec - r_now_sec - SEC_W'(usec_borrow);
                sum_result.delay_usec = usec_diff[USEC_W-1:0];
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_op == OP_CLEAR) begin
                r_count <= '0;
            end else if (pop_fire) begin
                r_count <= r_count - CNT_W'(1);
            end else if (ins_fire) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (pop_fire || sum_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_op;
            r_key.sec    <= i_wake_sec;
            r_key.usec   <= clamp_usec(i_wake_usec);
            r_key.id     <= i_waiter_id;
            r_key.mode   <= i_timer_mode;
            r_now_sec    <= i_now_sec;
            r_now_usec   <= clamp_usec(i_now_usec);
            r_nonempty   <= head_valid;
            r_popped     <= 1'b0;
            r_ins_status <= INS_NONE;
        end
        if (pop_fire) begin
            r_popped <= 1'b1;
        end
        if (r_state == ST_INSERT) begin
            r_ins_status <= ins_status;
        end
        if (pop_fire) begin
            r_out <= pop_result;
        end else if (sum_fire) begin
            r_out <= sum_result;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_kind               = r_out.kind;
    assign o_expired_id         = r_out.expired_id;
    assign o_timeout_status     = r_out.timeout_status;
    assign o_insert_status      = r_out.insert_status;
    assign o_queue_was_nonempty = r_out.nonempty;
    assign o_head_sec           = r_out.head_sec;
    assign o_head_usec          = r_out.head_usec;
    assign o_delay_sec          = r_out.delay_sec;
    assign o_delay_usec         = r_out.delay_usec;
    assign o_last               = r_out.last;

endmodule
